>>> rtl/wcc_pkg.sv
// Package for the window pixel CRC checker.
// Holds the configuration record, register indexes, field widths and the CRC fold.
// No dependencies.
package wcc_pkg;

  localparam int unsigned PosW       = 12;
  localparam int unsigned ColorW     = 32;
  localparam int unsigned CrcW       = 32;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned InDataW    = 56;
  localparam int unsigned MaxColumns = 4096;
  localparam int unsigned MaxRows    = 4096;
  localparam int unsigned LimitW     = 17;

  localparam logic [CrcW-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] CrcInit = 32'h0000_0000;

  typedef enum logic [CfgIndexW-1:0] {
    REG_CHECK_ENABLE     = 3'd0,
    REG_WINDOW_START_COL = 3'd1,
    REG_WINDOW_START_ROW = 3'd2,
    REG_WINDOW_END_COL   = 3'd3,
    REG_WINDOW_END_ROW   = 3'd4,
    REG_REFERENCE_CRC    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic            check_enable;
    logic [PosW-1:0] window_start_col;
    logic [PosW-1:0] window_start_row;
    logic [PosW-1:0] window_end_col;
    logic [PosW-1:0] window_end_row;
    logic [CrcW-1:0] reference_crc;
  } cfg_t;

  // Fold red, green and blue (24 bits, MSB first) into the CRC.
  function automatic logic [CrcW-1:0] crc_fold_rgb(input logic [CrcW-1:0] crc_in,
                                                   input logic [23:0]     rgb);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = crc_in;
    for (int i = 23; i >= 0; i--) begin
      fb  = crc[CrcW-1] ^ rgb[i];
      crc = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : CrcInit);
    end
    return crc;
  endfunction

endpackage

>>> rtl/wcc_cfg_regs.sv
// Configuration register file of the window pixel CRC checker.
// Depends on wcc_pkg.
module wcc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wcc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [wcc_pkg::CfgDataW-1:0]  cfg_data,
  output wcc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcc_pkg::REG_CHECK_ENABLE:     cfg.check_enable     <= cfg_data[0];
        wcc_pkg::REG_WINDOW_START_COL: cfg.window_start_col <= cfg_data[wcc_pkg::PosW-1:0];
        wcc_pkg::REG_WINDOW_START_ROW: cfg.window_start_row <= cfg_data[wcc_pkg::PosW-1:0];
        wcc_pkg::REG_WINDOW_END_COL:   cfg.window_end_col   <= cfg_data[wcc_pkg::PosW-1:0];
        wcc_pkg::REG_WINDOW_END_ROW:   cfg.window_end_row   <= cfg_data[wcc_pkg::PosW-1:0];
        wcc_pkg::REG_REFERENCE_CRC:    cfg.reference_crc    <= cfg_data[wcc_pkg::CrcW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/wcc_window.sv
// Window membership test for one pixel position.
// Depends on wcc_pkg.
module wcc_window (
  input  wcc_pkg::cfg_t               cfg,
  input  logic [wcc_pkg::PosW-1:0]    pixel_column,
  input  logic [wcc_pkg::PosW-1:0]    pixel_row,
  output logic                        in_window
);

  logic in_limits;

  assign in_limits = ({{(wcc_pkg::LimitW-wcc_pkg::PosW){1'b0}}, pixel_column}
                      < wcc_pkg::LimitW'(wcc_pkg::MaxColumns)) &&
                     ({{(wcc_pkg::LimitW-wcc_pkg::PosW){1'b0}}, pixel_row}
                      < wcc_pkg::LimitW'(wcc_pkg::MaxRows));

  assign in_window = in_limits &&
                     (pixel_column >= cfg.window_start_col) &&
                     (pixel_column <= cfg.window_end_col) &&
                     (pixel_row >= cfg.window_start_row) &&
                     (pixel_row <= cfg.window_end_row);

endmodule

>>> rtl/wcc_crc_core.sv
// CRC accumulator and result register of the window pixel CRC checker.
// Depends on wcc_pkg.
module wcc_crc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  wcc_pkg::cfg_t                 cfg,
  input  logic                          item_valid,
  input  logic [wcc_pkg::ColorW-1:0]    item_color,
  input  logic                          item_in_window,
  input  logic                          item_last,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wcc_pkg::CrcW-1:0]      out_crc,
  output logic                          out_mismatch
);

  logic [wcc_pkg::CrcW-1:0] crc_accumulator;
  logic [wcc_pkg::CrcW-1:0] crc_next;
  logic                     needs_slot;

  assign crc_next   = item_in_window ?
                      wcc_pkg::crc_fold_rgb(crc_accumulator, item_color[23:0]) :
                      crc_accumulator;
  assign needs_slot = cfg.check_enable && item_last;
  assign advance    = item_valid && (!needs_slot || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accumulator <= wcc_pkg::CrcInit;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (!cfg.check_enable || item_last) begin
          crc_accumulator <= wcc_pkg::CrcInit;
        end else begin
          crc_accumulator <= crc_next;
        end
        if (needs_slot) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && needs_slot) begin
      out_crc      <= crc_next;
      out_mismatch <= (crc_next != cfg.reference_crc);
    end
  end

endmodule

>>> rtl/window_pixel_crc_checker.sv
// Top level of the window pixel CRC checker.
// Depends on wcc_pkg, wcc_cfg_regs, wcc_window and wcc_crc_core.
//
// Takes one ARGB8888 pixel per clock and folds red, green and blue of every
// pixel inside the inclusive window into a CRC-32 (poly 04C11DB7, MSB first,
// init 0, no reflection, no final XOR). The frame-end pixel (tlast) yields one
// transaction with the CRC in tdata and the mismatch flag in tuser, then the
// CRC restarts from zero; with checking disabled nothing is reported. A pixel
// is registered at the input and, once taken, folded into the accumulator or,
// at a frame end, into the result register. One pixel per cycle is sustained,
// set by the combinational 24-bit CRC update. The input stalls only while a
// report waits in the result register and another frame end arrives.
module window_pixel_crc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wcc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [wcc_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_color[31:0], pixel_column[43:32], pixel_row[55:44]
  input  logic [wcc_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // window_crc[31:0]
  output logic [wcc_pkg::CrcW-1:0]      m_axis_tdata,
  // crc_mismatch[0]
  output logic                          m_axis_tuser
);

  wcc_pkg::cfg_t                 cfg;
  logic                          in_valid;
  logic [wcc_pkg::ColorW-1:0]    in_color;
  logic [wcc_pkg::PosW-1:0]      in_column;
  logic [wcc_pkg::PosW-1:0]      in_row;
  logic                          in_last;
  logic                          in_window;
  logic                          advance;

  wcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_color  <= s_axis_tdata[31:0];
      in_column <= s_axis_tdata[43:32];
      in_row    <= s_axis_tdata[55:44];
      in_last   <= s_axis_tlast;
    end
  end

  wcc_window u_window (
    .cfg          (cfg),
    .pixel_column (in_column),
    .pixel_row    (in_row),
    .in_window    (in_window)
  );

  wcc_crc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (in_valid),
    .item_color     (in_color),
    .item_in_window (in_window),
    .item_last      (in_last),
    .advance        (advance),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_crc        (m_axis_tdata),
    .out_mismatch   (m_axis_tuser)
  );

endmodule

>>> rtl/wcc_checker.sv
// Port-level checker for the window pixel CRC checker, with its bind.
// Depends on wcc_pkg and window_pixel_crc_checker.
module wcc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wcc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [wcc_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [wcc_pkg::CrcW-1:0]      m_axis_tdata,
  input  logic                          m_axis_tuser
);

  logic [wcc_pkg::CrcW-1:0] reference_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_crc <= '0;
    end else if (cfg_we && cfg_index == wcc_pkg::REG_REFERENCE_CRC) begin
      reference_crc <= cfg_data[wcc_pkg::CrcW-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  a_report_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result transaction without a frame-end pixel two cycles before");

  a_mismatch_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == (m_axis_tdata != reference_crc))
    else $error("mismatch flag disagrees with reference CRC");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with the result register free");

endmodule

bind window_pixel_crc_checker wcc_checker u_wcc_checker (.*);
